// ===== src/tha_pkg.sv =====
// Shared types and constants for the triangle Heron area core.
// Holds the channel structs and the lane struct carried through the root cells.
// No dependencies.
`default_nettype none

package tha_pkg;

    localparam int SIDE_W  = 16;
    localparam int FACT_W  = 16;
    localparam int PERIM_W = 17;
    localparam int AREA_W  = 31;
    localparam int PROD_W  = 2 * AREA_W;

    typedef struct packed {
        logic signed [SIDE_W-1:0] side_a;
        logic signed [SIDE_W-1:0] side_b;
        logic signed [SIDE_W-1:0] side_c;
    } tri_in_t;

    typedef struct packed {
        logic               valid_res;
        logic [PERIM_W-1:0] perimeter;
        logic [AREA_W-1:0]  area;
    } tri_out_t;

    // Item after validation: factors are zero for a rejected triangle.
    typedef struct packed {
        logic               ok;
        logic [PERIM_W-1:0] perim;
        logic [FACT_W-1:0]  fa;
        logic [FACT_W-1:0]  fb;
        logic [FACT_W-1:0]  fc;
    } tri_fact_t;

    // Item inside the square-root chain.
    typedef struct packed {
        logic               ok;
        logic [PERIM_W-1:0] perim;
        logic [AREA_W-1:0]  root;
        logic [PROD_W-1:0]  rem;
    } sqrt_lane_t;

endpackage

`default_nettype wire

// ===== src/tha_prep.sv =====
// Input stage: checks the triangle condition and forms perimeter and factors.
// Depends on tha_pkg.
`default_nettype none

module tha_prep
    import tha_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      up_valid,
    output logic           up_ready,
    input  wire tri_in_t   up_data,
    output logic           dn_valid,
    input  wire logic      dn_ready,
    output tri_fact_t      dn_data
);

    logic       valid_reg;
    logic       valid_next;
    tri_fact_t  data_reg;
    tri_fact_t  data_next;

    logic [SIDE_W-2:0] ua;
    logic [SIDE_W-2:0] ub;
    logic [SIDE_W-2:0] uc;
    logic [SIDE_W-1:0] s_bc;
    logic [SIDE_W-1:0] s_ac;
    logic [SIDE_W-1:0] s_ab;
    logic              nonneg;
    logic              ok;

    always_comb
    begin
        ua     = up_data.side_a[SIDE_W-2:0];
        ub     = up_data.side_b[SIDE_W-2:0];
        uc     = up_data.side_c[SIDE_W-2:0];
        s_bc   = {1'b0, ub} + {1'b0, uc};
        s_ac   = {1'b0, ua} + {1'b0, uc};
        s_ab   = {1'b0, ua} + {1'b0, ub};
        nonneg = !up_data.side_a[SIDE_W-1] && !up_data.side_b[SIDE_W-1]
                 && !up_data.side_c[SIDE_W-1];
        ok     = nonneg && ({1'b0, ua} < s_bc) && ({1'b0, ub} < s_ac)
                 && ({1'b0, uc} < s_ab);

        up_ready = !valid_reg || dn_ready;
        valid_next = up_ready ? up_valid : valid_reg;
        data_next  = data_reg;
        if (up_ready && up_valid)
        begin
            data_next.ok = ok;
            if (ok)
            begin
                data_next.perim = {1'b0, s_bc} + {2'b00, ua};
                data_next.fa    = s_bc - {1'b0, ua};
                data_next.fb    = s_ac - {1'b0, ub};
                data_next.fc    = s_ab - {1'b0, uc};
            end
            else
            begin
                data_next.perim = '0;
                data_next.fa    = '0;
                data_next.fb    = '0;
                data_next.fc    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

// ===== src/tha_mul.sv =====
// Three-stage product of perimeter and the three factors, split into
// narrow partial products. Depends on tha_pkg.
`default_nettype none

module tha_mul
    import tha_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      up_valid,
    output logic           up_ready,
    input  wire tri_fact_t up_data,
    output logic           dn_valid,
    input  wire logic      dn_ready,
    output sqrt_lane_t     dn_data
);

    localparam int M1_W  = PERIM_W + FACT_W;
    localparam int M2_W  = 2 * FACT_W;
    localparam int HALF  = M2_W / 2;
    localparam int PP_W  = M1_W + HALF;

    // Stage 1: p*fa and fb*fc
    logic               v1_reg;
    logic               ok1_reg;
    logic [PERIM_W-1:0] perim1_reg;
    logic [M1_W-1:0]    m1_reg;
    logic [M2_W-1:0]    m2_reg;
    // Stage 2: two partial products
    logic               v2_reg;
    logic               ok2_reg;
    logic [PERIM_W-1:0] perim2_reg;
    logic [PP_W-1:0]    plo_reg;
    logic [PP_W-1:0]    phi_reg;
    // Stage 3: summed product
    logic               v3_reg;
    sqrt_lane_t         lane3_reg;

    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic [PROD_W-1:0] sum3;

    always_comb
    begin
        rdy3 = !v3_reg || dn_ready;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;
        up_ready = rdy1;
        sum3 = PROD_W'(plo_reg) + PROD_W'({phi_reg, {HALF{1'b0}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= up_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && up_valid)
        begin
            ok1_reg    <= up_data.ok;
            perim1_reg <= up_data.perim;
            m1_reg     <= M1_W'(up_data.perim) * M1_W'(up_data.fa);
            m2_reg     <= M2_W'(up_data.fb) * M2_W'(up_data.fc);
        end
        if (rdy2 && v1_reg)
        begin
            ok2_reg    <= ok1_reg;
            perim2_reg <= perim1_reg;
            plo_reg    <= PP_W'(m1_reg) * PP_W'(m2_reg[HALF-1:0]);
            phi_reg    <= PP_W'(m1_reg) * PP_W'(m2_reg[M2_W-1:HALF]);
        end
        if (rdy3 && v2_reg)
        begin
            lane3_reg.ok    <= ok2_reg;
            lane3_reg.perim <= perim2_reg;
            lane3_reg.root  <= '0;
            lane3_reg.rem   <= sum3;
        end
    end

    assign dn_valid = v3_reg;
    assign dn_data  = lane3_reg;

endmodule

`default_nettype wire

// ===== src/tha_sqrt_cell.sv =====
// One cell of the square-root chain: decides one root bit and passes the
// lane on. Depends on tha_pkg.
`default_nettype none

module tha_sqrt_cell
    import tha_pkg::*;
#(
    parameter int BIT = AREA_W - 1
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       up_valid,
    output logic            up_ready,
    input  wire sqrt_lane_t up_data,
    output logic            dn_valid,
    input  wire logic       dn_ready,
    output sqrt_lane_t      dn_data
);

    localparam int TW = PROD_W + 1;

    logic       valid_reg;
    logic       valid_next;
    sqrt_lane_t lane_reg;
    sqrt_lane_t lane_next;
    logic [TW-1:0] trial;

    always_comb
    begin
        // trial = (2*root + 2^BIT) * 2^BIT
        trial = (TW'(up_data.root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
        up_ready   = !valid_reg || dn_ready;
        valid_next = up_ready ? up_valid : valid_reg;
        lane_next  = lane_reg;
        if (up_ready && up_valid)
        begin
            lane_next = up_data;
            if (TW'(up_data.rem) >= trial)
            begin
                lane_next.rem  = up_data.rem - trial[PROD_W-1:0];
                lane_next.root = up_data.root | (AREA_W'(1) << BIT);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = lane_reg;

endmodule

`default_nettype wire

// ===== src/triangle_heron_area_core.sv =====
// Top level of the triangle Heron area core: validation, product stages,
// a chain of square-root cells and the result register.
// Depends on tha_pkg, tha_prep, tha_mul and tha_sqrt_cell.
//
//   channel   direction   handshake             payload
//   tri       in          tri_valid/tri_stall   tri_data  (tri_in_t)
//   res       out         res_valid/res_stall   res_data  (tri_out_t)
//
// One triangle enters per cycle while tri_stall is low; each result passes
// through one validation stage, three multiply stages, one cell per
// root bit (31 cells) and the result register.
// Reset clears only the stage valid flags; payload registers hold garbage.
// Every stage advances on its own: a stage takes a new transfer when it is
// empty or its neighbor takes its content, so bubbles collapse under stall.
`default_nettype none

module triangle_heron_area_core
    import tha_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     tri_valid,
    output logic          tri_stall,
    input  wire tri_in_t  tri_data,
    output logic          res_valid,
    input  wire logic     res_stall,
    output tri_out_t      res_data
);

    localparam int NCELL = AREA_W;

    logic       tri_ready;
    logic       prep_valid;
    logic       prep_ready;
    tri_fact_t  prep_data;

    // Chain links: index 0 feeds the top cell, index NCELL leaves the last.
    logic       link_valid [NCELL+1];
    logic       link_ready [NCELL+1];
    sqrt_lane_t link_data  [NCELL+1];

    logic       out_valid_reg;
    logic       out_valid_next;
    tri_out_t   out_data_reg;
    tri_out_t   out_data_next;

    assign tri_stall = !tri_ready;

    // Validate the sides and form perimeter and factors
    tha_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (tri_valid),
        .up_ready (tri_ready),
        .up_data  (tri_data),
        .dn_valid (prep_valid),
        .dn_ready (prep_ready),
        .dn_data  (prep_data)
    );

    // Form the 62-bit radicand
    tha_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (prep_valid),
        .up_ready (prep_ready),
        .up_data  (prep_data),
        .dn_valid (link_valid[0]),
        .dn_ready (link_ready[0]),
        .dn_data  (link_data[0])
    );

    // One cell per root bit, most significant first
    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        tha_sqrt_cell #(
            .BIT (NCELL - 1 - g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[g]),
            .up_ready (link_ready[g]),
            .up_data  (link_data[g]),
            .dn_valid (link_valid[g+1]),
            .dn_ready (link_ready[g+1]),
            .dn_data  (link_data[g+1])
        );
    end

    // Result register: load when empty or when the current result transfers
    always_comb
    begin
        link_ready[NCELL] = !out_valid_reg || !res_stall;
        out_valid_next    = link_ready[NCELL] ? link_valid[NCELL] : out_valid_reg;
        out_data_next     = out_data_reg;
        if (link_ready[NCELL] && link_valid[NCELL])
        begin
            out_data_next.valid_res = link_data[NCELL].ok;
            out_data_next.perimeter = link_data[NCELL].perim;
            out_data_next.area      = link_data[NCELL].root;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

endmodule

`default_nettype wire
